>>> hdl/okst_pkg.sv
package okst_pkg;

  // Operation codes as they arrive on the input channel.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TEST   = 2'd2
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_NULL = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RD,
    S_CMP,
    S_SH_RD,
    S_SH_WR,
    S_RESP
  } state_t;

  localparam int unsigned OP_BITS   = 2;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SIZE_W    = 7;

  // Controller to datapath.
  typedef struct packed {
    logic    load;       // capture op and key from the input transfer
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_next;    // read address idx+1 instead of idx
    logic    wr_append;  // mem[count] <= key
    logic    wr_shift;   // mem[idx] <= last read data
    logic    cnt_inc;
    logic    cnt_dec;
    logic    st_set;     // latch pending status
    status_t st_val;
    logic    res_load;   // move pending result into output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_t  op;
    logic key_null;
    logic cnt_zero;
    logic cnt_full;
    logic match;
    logic last;         // idx is the last valid slot
    logic shift_last;   // idx+1 is the last valid slot
    logic res_free;     // output register can take a result this cycle
  } stat_t;

endpackage

>>> hdl/okst_if.sv
interface okst_in_if;
  logic                          valid;
  logic                          ready;
  logic [okst_pkg::OP_BITS-1:0]  operation;
  logic [okst_pkg::KEY_W-1:0]    key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface okst_out_if;
  logic                          valid;
  logic                          ready;
  logic [okst_pkg::STATUS_W-1:0] status;
  logic [okst_pkg::SIZE_W-1:0]   set_size;

  modport source (output valid, output status, output set_size, input ready);
  modport sink   (input valid, input status, input set_size, output ready);
endinterface

>>> hdl/okst_dp.sv
module okst_dp #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [okst_pkg::OP_BITS-1:0]  in_operation,
  input  logic [okst_pkg::KEY_W-1:0]    in_key,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [okst_pkg::STATUS_W-1:0] out_status,
  output logic [okst_pkg::SIZE_W-1:0]   out_set_size,
  input  okst_pkg::cmd_t                cmd,
  output okst_pkg::stat_t               stat
);

  // Stored key width: only the low KEY_BITS of the 32-bit key count.
  localparam int unsigned SW = (KEY_BITS < okst_pkg::KEY_W) ? KEY_BITS : okst_pkg::KEY_W;
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [SW-1:0]        mem [CAPACITY];
  logic [SW-1:0]        rd_data_r;
  logic [SW-1:0]        key_r;
  okst_pkg::op_t        op_r;
  logic [IW-1:0]        idx_r;
  logic [CW-1:0]        count_r;
  okst_pkg::status_t    pend_r;
  logic                 out_valid_r;
  okst_pkg::status_t    out_status_r;
  logic [okst_pkg::SIZE_W-1:0] out_size_r;

  okst_pkg::op_t        op_dec;
  logic [IW-1:0]        rd_addr;
  logic [IW-1:0]        wr_addr;
  logic [SW-1:0]        wr_data;
  logic                 wr_en;
  logic [CW:0]          idx_p1;
  logic [CW:0]          idx_p2;

  always_comb begin
    unique case (in_operation)
      okst_pkg::OP_ADD:    op_dec = okst_pkg::OP_ADD;
      okst_pkg::OP_REMOVE: op_dec = okst_pkg::OP_REMOVE;
      default:             op_dec = okst_pkg::OP_TEST;
    endcase
  end

  assign idx_p1  = (CW + 1)'(idx_r) + (CW + 1)'(1);
  assign idx_p2  = (CW + 1)'(idx_r) + (CW + 1)'(2);
  assign rd_addr = cmd.rd_next ? idx_p1[IW-1:0] : idx_r;
  assign wr_en   = cmd.wr_append | cmd.wr_shift;
  assign wr_addr = cmd.wr_append ? count_r[IW-1:0] : idx_r;
  assign wr_data = cmd.wr_append ? key_r : rd_data_r;

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key[SW-1:0];
      op_r  <= op_dec;
    end
    if (cmd.st_set) begin
      pend_r <= cmd.st_val;
    end
    if (cmd.res_load) begin
      out_status_r <= pend_r;
      out_size_r   <= okst_pkg::SIZE_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_p1[IW-1:0];
      end
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.op         = op_r;
  assign stat.key_null   = (key_r == '0);
  assign stat.cnt_zero   = (count_r == '0);
  assign stat.cnt_full   = (count_r == CW'(CAPACITY));
  assign stat.match      = (rd_data_r == key_r);
  assign stat.last       = (idx_p1 >= (CW + 1)'(count_r));
  assign stat.shift_last = (idx_p2 >= (CW + 1)'(count_r));
  assign stat.res_free   = ~out_valid_r | out_ready;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_set_size = out_size_r;

endmodule

>>> hdl/okst_ctrl.sv
module okst_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  okst_pkg::stat_t stat,
  output okst_pkg::cmd_t  cmd
);

  okst_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= okst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      okst_pkg::S_IDLE: begin
        if (in_valid) state_nxt = okst_pkg::S_CHECK;
      end
      okst_pkg::S_CHECK: begin
        if (stat.key_null || stat.cnt_zero) state_nxt = okst_pkg::S_RESP;
        else                                state_nxt = okst_pkg::S_RD;
      end
      okst_pkg::S_RD: state_nxt = okst_pkg::S_CMP;
      okst_pkg::S_CMP: begin
        if (stat.match) begin
          if (stat.op == okst_pkg::OP_REMOVE && !stat.last) state_nxt = okst_pkg::S_SH_RD;
          else                                              state_nxt = okst_pkg::S_RESP;
        end else if (stat.last) begin
          state_nxt = okst_pkg::S_RESP;
        end else begin
          state_nxt = okst_pkg::S_RD;
        end
      end
      okst_pkg::S_SH_RD: state_nxt = okst_pkg::S_SH_WR;
      okst_pkg::S_SH_WR: begin
        if (stat.shift_last) state_nxt = okst_pkg::S_RESP;
        else                 state_nxt = okst_pkg::S_SH_RD;
      end
      okst_pkg::S_RESP: begin
        if (stat.res_free) state_nxt = okst_pkg::S_IDLE;
      end
      default: state_nxt = okst_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      okst_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      okst_pkg::S_CHECK: begin
        cmd.idx_clr = 1'b1;
        if (stat.key_null) begin
          cmd.st_set = 1'b1;
          cmd.st_val = okst_pkg::ST_NULL;
        end else if (stat.cnt_zero) begin
          // empty set: key is absent
          cmd.st_set = 1'b1;
          if (stat.op == okst_pkg::OP_ADD) begin
            cmd.wr_append = 1'b1;
            cmd.cnt_inc   = 1'b1;
            cmd.st_val    = okst_pkg::ST_DONE;
          end else begin
            cmd.st_val    = okst_pkg::ST_MISS;
          end
        end
      end
      okst_pkg::S_RD: begin
      end
      okst_pkg::S_CMP: begin
        if (stat.match) begin
          cmd.st_set = 1'b1;
          unique case (stat.op)
            okst_pkg::OP_ADD: cmd.st_val = okst_pkg::ST_MISS;
            okst_pkg::OP_REMOVE: begin
              cmd.st_val = okst_pkg::ST_DONE;
              if (stat.last) cmd.cnt_dec = 1'b1;
            end
            default: cmd.st_val = okst_pkg::ST_DONE;
          endcase
        end else if (stat.last) begin
          // scan exhausted without a hit
          cmd.st_set = 1'b1;
          if (stat.op == okst_pkg::OP_ADD) begin
            if (stat.cnt_full) begin
              cmd.st_val = okst_pkg::ST_FULL;
            end else begin
              cmd.wr_append = 1'b1;
              cmd.cnt_inc   = 1'b1;
              cmd.st_val    = okst_pkg::ST_DONE;
            end
          end else begin
            cmd.st_val = okst_pkg::ST_MISS;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      okst_pkg::S_SH_RD: begin
        cmd.rd_next = 1'b1;
      end
      okst_pkg::S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        if (stat.shift_last) cmd.cnt_dec = 1'b1;
        else                 cmd.idx_inc = 1'b1;
      end
      okst_pkg::S_RESP: begin
        cmd.res_load = stat.res_free;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/ordered_key_set_table.sv
// Ordered key set table: holds up to CAPACITY distinct nonzero keys in the
// order they were added. Each input transfer carries an operation (add,
// remove, test; code 3 acts as test) and a key, of which only the low
// KEY_BITS bits count; every input yields exactly one result transfer with
// a status (done, duplicate/absent, null key, table full) and the set size
// after the operation (low 7 bits of the count). Keys sit in a single-port
// write / registered-read memory, so each operation walks it one slot at a
// time: each slot examined takes a read and a compare, and a remove moves
// every later entry down one place with a read and a write each. A null key
// or an empty set goes straight to the result. One item is worked on at a
// time; the next input is taken in the cycle after the result enters the
// output register, even if that result is still waiting to be taken. No
// clearing pass is needed after reset.
module ordered_key_set_table #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  okst_in_if.sink    in_ch,
  okst_out_if.source out_ch
);

  okst_pkg::cmd_t  cmd;
  okst_pkg::stat_t stat;

  // Sequencer: scan, append, and remove compaction.
  okst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Key memory, count, index and the output register.
  okst_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_ch.operation),
    .in_key       (in_ch.key),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_status   (out_ch.status),
    .out_set_size (out_ch.set_size),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

>>> dv/okst_checker.sv
// Watches both channels, keeps a shadow copy of the key set and compares
// every result transfer with the oldest outstanding prediction.
module okst_checker #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  okst_in_if          in_mon,
  okst_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned results_owed
);

  typedef struct packed {
    okst_pkg::status_t               status;
    logic [okst_pkg::SIZE_W-1:0]     set_size;
  } key_result_t;

  localparam logic [okst_pkg::KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= okst_pkg::KEY_W) ? '1 : ((1 << KEY_BITS) - 1);

  logic [okst_pkg::KEY_W-1:0] held_keys [CAPACITY];
  int unsigned                held_count;
  key_result_t                owed_results[$];
  int unsigned                errors;

  // Applies one operation to the shadow set and returns the answer.
  function automatic key_result_t apply_key_op(logic [okst_pkg::OP_BITS-1:0] op,
                                               logic [okst_pkg::KEY_W-1:0] raw_key);
    key_result_t                res;
    logic [okst_pkg::KEY_W-1:0] k;
    int unsigned                slot;
    k = raw_key & KEY_MASK;
    slot = held_count;
    for (int unsigned i = 0; i < held_count; i++) begin
      if (held_keys[i] == k && slot == held_count) slot = i;
    end
    if (k == '0) begin
      res.status = okst_pkg::ST_NULL;
    end else if (op == okst_pkg::OP_ADD) begin
      if (slot < held_count) begin
        res.status = okst_pkg::ST_MISS;
      end else if (held_count >= CAPACITY) begin
        res.status = okst_pkg::ST_FULL;
      end else begin
        held_keys[held_count] = k;
        held_count++;
        res.status = okst_pkg::ST_DONE;
      end
    end else if (op == okst_pkg::OP_REMOVE) begin
      if (slot < held_count) begin
        for (int unsigned i = slot; i + 1 < held_count; i++) held_keys[i] = held_keys[i + 1];
        held_count--;
        res.status = okst_pkg::ST_DONE;
      end else begin
        res.status = okst_pkg::ST_MISS;
      end
    end else begin
      // test; the spare code 3 decodes the same way
      res.status = (slot < held_count) ? okst_pkg::ST_DONE : okst_pkg::ST_MISS;
    end
    res.set_size = okst_pkg::SIZE_W'(held_count);
    return res;
  endfunction

  always @(posedge clk) begin
    key_result_t want;
    if (!rst_n) begin
      held_count = 0;
      owed_results.delete();
      errors = 0;
    end else begin
      // a result leaving at this edge always belongs to an earlier input
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, status %0d set_size %0d", $time,
                   out_mon.status, out_mon.set_size);
        end else begin
          want = owed_results.pop_front();
          if (out_mon.status !== want.status || out_mon.set_size !== want.set_size) begin
            errors++;
            $display("%0t: mismatch, expected status %0d set_size %0d, got status %0d set_size %0d",
                     $time, want.status, want.set_size, out_mon.status, out_mon.set_size);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        owed_results.push_back(apply_key_op(in_mon.operation, in_mon.key));
    end
    fail_count   <= errors;
    results_owed <= owed_results.size();
  end

endmodule

>>> dv/tb_top.sv
// Stimulus and verdict for the ordered key set table. The checker beside the
// block does all prediction; this module only drives traffic, pauses the
// result side, and decides pass or fail.
module tb_top;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned KEY_BITS     = 32;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned HOLD_CYCLES  = 150;   // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 300;   // exceeds the slowest operation
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no transfer at all

  // Spare operation code; the block treats it as a membership test.
  localparam logic [okst_pkg::OP_BITS-1:0] OP_TEST_ALT = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  okst_in_if  in_ch ();
  okst_out_if out_ch ();

  int unsigned fail_count;
  int unsigned results_owed;

  // Idle percentages per side, changed by the stimulus as phases advance.
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 61;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;

  // Keys the stimulus believes are held; only used to aim at present keys.
  logic [okst_pkg::KEY_W-1:0] live_keys[$];

  int unsigned quiet_cycles;

  ordered_key_set_table #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  okst_checker #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a correct run never goes this long without some transfer,
  // even with the deepest remove plus the long receiver hold-off.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("[ordered_key_set_table] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Fresh nonzero key: mostly full-width, some small so values collide.
  function automatic logic [okst_pkg::KEY_W-1:0] fresh_key();
    logic [okst_pkg::KEY_W-1:0] k;
    k = ($urandom_range(3) == 0) ? okst_pkg::KEY_W'($urandom_range(255, 1))
                                 : okst_pkg::KEY_W'($urandom);
    if (k == '0) k = 1;
    return k;
  endfunction

  // Present key when there is one, else a fresh one (likely absent).
  function automatic logic [okst_pkg::KEY_W-1:0] live_key();
    if (live_keys.size() == 0) return fresh_key();
    return live_keys[$urandom_range(live_keys.size() - 1)];
  endfunction

  // One input transfer: random idle gap, then hold valid until accepted.
  // Exactly one nonblocking write to valid per clock step.
  task automatic send_op(input logic [okst_pkg::OP_BITS-1:0] op,
                         input logic [okst_pkg::KEY_W-1:0] k);
    int found;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.key       <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // track what is probably held so later items can hit it
    found = -1;
    foreach (live_keys[i]) if (live_keys[i] == k) found = i;
    if (k != '0) begin
      if (op == okst_pkg::OP_ADD && found < 0 && live_keys.size() < CAPACITY)
        live_keys.push_back(k);
      else if (op == okst_pkg::OP_REMOVE && found >= 0)
        live_keys.delete(found);
    end
  endtask

  // Receiver: random ready, plus one long hold-off once asked for, so the
  // output register stays full and the input side backs up.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ch.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    logic [okst_pkg::OP_BITS-1:0] op;
    logic [okst_pkg::KEY_W-1:0]   k;
    int unsigned                  roll;
    bit                           growing;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= okst_pkg::OP_ADD;
    in_ch.key       <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: null key on every code, empty-set misses, extreme keys,
    // duplicate add, spare code as test, removes from middle, head and tail.
    send_op(okst_pkg::OP_ADD, '0);
    send_op(okst_pkg::OP_REMOVE, '0);
    send_op(okst_pkg::OP_TEST, '0);
    send_op(OP_TEST_ALT, '0);
    send_op(okst_pkg::OP_TEST, 32'h0000_0001);
    send_op(okst_pkg::OP_REMOVE, 32'hFFFF_FFFF);
    send_op(okst_pkg::OP_ADD, 32'hFFFF_FFFF);
    send_op(okst_pkg::OP_ADD, 32'h0000_0001);
    send_op(okst_pkg::OP_ADD, 32'h8000_0000);
    send_op(okst_pkg::OP_ADD, 32'hFFFF_FFFF);
    send_op(okst_pkg::OP_TEST, 32'h0000_0001);
    send_op(OP_TEST_ALT, 32'h8000_0000);
    send_op(okst_pkg::OP_TEST, 32'h0000_0002);
    send_op(okst_pkg::OP_ADD, 32'h7FFF_FFFE);
    send_op(okst_pkg::OP_REMOVE, 32'h0000_0001);
    send_op(okst_pkg::OP_REMOVE, 32'h0000_0001);
    send_op(okst_pkg::OP_REMOVE, 32'hFFFF_FFFF);
    send_op(okst_pkg::OP_REMOVE, 32'h7FFF_FFFE);
    send_op(okst_pkg::OP_REMOVE, 32'h8000_0000);
    send_op(OP_TEST_ALT, 32'h8000_0000);

    // Random: alternate grow and shrink stretches so the set fills to
    // capacity (full and duplicate-on-full) and drains again.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 35;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
      end
      growing = (n % 180) < 100;
      roll = $urandom_range(99);
      if (roll < 6) begin
        op = okst_pkg::OP_BITS'($urandom_range(3));
        k  = '0;
      end else if (roll < 12) begin
        op = okst_pkg::OP_BITS'($urandom_range(3));
        k  = okst_pkg::KEY_W'($urandom);
      end else begin
        roll = $urandom_range(99);
        if (growing ? roll < 88 : roll < 20) begin
          op = okst_pkg::OP_ADD;
          k  = ($urandom_range(9) == 0) ? live_key() : fresh_key();
        end else if (growing ? roll < 94 : roll < 75) begin
          op = okst_pkg::OP_REMOVE;
          k  = ($urandom_range(99) < 85) ? live_key() : fresh_key();
        end else begin
          op = $urandom_range(1) ? okst_pkg::OP_TEST : OP_TEST_ALT;
          k  = ($urandom_range(99) < 60) ? live_key() : fresh_key();
        end
      end
      send_op(op, k);
    end
    in_ch.valid <= 1'b0;

    // Let the checker see the last transfer, drain, then idle out the
    // longest latency to catch any stray result.
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ordered_key_set_table] OK");
    end else begin
      $display("[ordered_key_set_table] ERROR");
    end
    $finish;
  end

endmodule
